>>> rtl/core/mt_pkg.sv
// Shared types and constants for the MT19937 word generator.
// No dependencies; imported by every module of the generator.
package mt_pkg;

	// Geometry of the state block
	localparam int unsigned STATE_WORDS   = 624;
	localparam int unsigned MIDDLE_OFFSET = 397;
	localparam int unsigned WORD_W        = 32;
	localparam int unsigned ADDR_W        = $clog2(STATE_WORDS);
	localparam int unsigned POS_W         = $clog2(STATE_WORDS + 1);
	localparam int unsigned FAR_SPLIT     = STATE_WORDS - MIDDLE_OFFSET;

	// Recurrence and tempering constants
	localparam logic [WORD_W-1:0] SEED_DEFAULT = 32'd5489;
	localparam logic [WORD_W-1:0] INIT_MULT    = 32'd1812433253;
	localparam logic [WORD_W-1:0] TWIST_MATRIX = 32'h9908_B0DF;
	localparam logic [WORD_W-1:0] TEMPER_B     = 32'h9D2C_5680;
	localparam logic [WORD_W-1:0] TEMPER_C     = 32'hEFC6_0000;

	// Command codes on func
	localparam logic FUNC_DRAW   = 1'b0;
	localparam logic FUNC_RESEED = 1'b1;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FILL,
		ST_REGEN_PRIME,
		ST_REGEN_LOAD,
		ST_REGEN_RUN,
		ST_DRAW_ISSUE
	} mt_state_t;

	// Write port of the state memory
	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] addr;
		logic [WORD_W-1:0] data;
	} mem_wr_t;

endpackage

>>> rtl/core/mt_state_mem.sv
// State block memory: one write port, two registered read ports.
// Depends on mt_pkg for geometry and the write port struct.
module mt_state_mem
	import mt_pkg::*;
(
	input  logic              clk,
	input  mem_wr_t           wr,
	input  logic [ADDR_W-1:0] raddr_a,
	input  logic [ADDR_W-1:0] raddr_b,
	output logic [WORD_W-1:0] rdata_a,
	output logic [WORD_W-1:0] rdata_b
);

	logic [WORD_W-1:0] mem [STATE_WORDS];

	// Write one word per cycle
	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem[wr.addr] <= wr.data;
		end
	end

	// Register both read ports
	always_ff @(posedge clk) begin
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

>>> rtl/core/mt_temper.sv
// Output stage: tempers a word read from the state block and registers the result.
// Depends on mt_pkg for word width and tempering masks.
module mt_temper
	import mt_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rd_valid_s1,
	input  logic [WORD_W-1:0] rd_word,
	output logic [WORD_W-1:0] random_word,
	output logic              word_valid
);

	logic [WORD_W-1:0] t1;
	logic [WORD_W-1:0] t2;
	logic [WORD_W-1:0] t3;
	logic [WORD_W-1:0] tempered;

	// Apply the four tempering shifts
	always_comb begin
		t1       = rd_word ^ (rd_word >> 11);
		t2       = t1 ^ ((t1 << 7) & TEMPER_B);
		t3       = t2 ^ ((t2 << 15) & TEMPER_C);
		tempered = t3 ^ (t3 >> 18);
	end

	// Hold the strobe for exactly one cycle per draw
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_valid <= 1'b0;
		end else begin
			word_valid <= rd_valid_s1;
		end
	end

	// Capture the tempered word
	always_ff @(posedge clk) begin
		if (rd_valid_s1) begin
			random_word <= tempered;
		end
	end

endmodule

>>> rtl/core/mersenne_twister_generator.sv
// Top level of the MT19937 generator: sequencer, seed fill and regeneration datapath.
// Depends on mt_pkg, mt_state_mem and mt_temper.
//
//   channel   ports                       direction  transfer
//   command   start, busy, func,          in         start high while busy low
//             seed_value
//   result    word_valid, random_word     out        word_valid high, one cycle
//
// A draw with words left is taken while busy stays low, so draws can run every
// cycle; each word is registered by the memory read and then by the temper stage.
// A draw that finds the block used up holds busy through regeneration (prime, load,
// run through the memory's two read ports and one write port) and its draw issue.
// A reseed holds busy while it writes the block, one seed recurrence word per cycle.
// After reset the block fills itself from the default seed, busy high.
// Results cannot be stalled; word_valid is a one-cycle strobe.
module mersenne_twister_generator
	import mt_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic              func,
	input  logic [WORD_W-1:0] seed_value,
	output logic [WORD_W-1:0] random_word,
	output logic              word_valid
);

	localparam logic [ADDR_W-1:0] LAST_IDX  = ADDR_W'(STATE_WORDS - 1);
	localparam logic [ADDR_W-1:0] WRAP_IDX  = ADDR_W'(STATE_WORDS - 2);
	localparam logic [ADDR_W-1:0] SPLIT_IDX = ADDR_W'(FAR_SPLIT);
	localparam logic [ADDR_W-1:0] MID_IDX   = ADDR_W'(MIDDLE_OFFSET);
	localparam logic [POS_W-1:0]  POS_END   = POS_W'(STATE_WORDS);

	mt_state_t         state_q;
	mt_state_t         state_d;
	logic [ADDR_W-1:0] idx_q;
	logic [POS_W-1:0]  pos_q;
	logic [WORD_W-1:0] seed_q;
	logic [WORD_W-1:0] prior_q;
	logic [WORD_W-1:0] cur_q;
	logic              draw_s1;

	logic              accept;
	logic              used_up;
	logic              draw_issue;
	logic [ADDR_W-1:0] raddr_a;
	logic [ADDR_W-1:0] raddr_b;
	logic [WORD_W-1:0] rdata_a;
	logic [WORD_W-1:0] rdata_b;
	mem_wr_t           wr;

	logic [WORD_W-1:0] fill_mixed;
	logic [WORD_W-1:0] fill_word;
	logic [WORD_W-1:0] twist_joined;
	logic [WORD_W-1:0] twist_word;
	logic [ADDR_W-1:0] idx_next;
	logic [ADDR_W-1:0] nbr_next;
	logic [ADDR_W-1:0] far_next;

	assign accept  = start && !busy;
	assign used_up = (pos_q >= POS_END);

	// Seed recurrence: next word from the prior one and its index
	always_comb begin
		fill_mixed = prior_q ^ (prior_q >> 30);
		if (idx_q == '0) begin
			fill_word = seed_q;
		end else begin
			fill_word = (fill_mixed * INIT_MULT) + {{(WORD_W-ADDR_W){1'b0}}, idx_q};
		end
	end

	// Twist: combine word k, word k+1 and the far word
	always_comb begin
		twist_joined = {cur_q[WORD_W-1], rdata_a[WORD_W-2:0]};
		twist_word   = rdata_b ^ (twist_joined >> 1) ^ (rdata_a[0] ? TWIST_MATRIX : '0);
	end

	// Read addresses for the next regeneration step
	always_comb begin
		idx_next = idx_q + 1'b1;
		nbr_next = (idx_q == WRAP_IDX) ? '0 : idx_q + ADDR_W'(2);
		if (idx_next < SPLIT_IDX) begin
			far_next = idx_next + MID_IDX;
		end else begin
			far_next = idx_next - SPLIT_IDX;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (func == FUNC_RESEED) begin
						state_d = ST_FILL;
					end else if (used_up) begin
						state_d = ST_REGEN_PRIME;
					end
				end
			end
			ST_FILL: begin
				if (idx_q == LAST_IDX) begin
					state_d = ST_IDLE;
				end
			end
			ST_REGEN_PRIME: state_d = ST_REGEN_LOAD;
			ST_REGEN_LOAD:  state_d = ST_REGEN_RUN;
			ST_REGEN_RUN: begin
				if (idx_q == LAST_IDX) begin
					state_d = ST_DRAW_ISSUE;
				end
			end
			ST_DRAW_ISSUE:  state_d = ST_IDLE;
			default:        state_d = ST_IDLE;
		endcase
	end

	// State outputs: busy, memory ports, draw issue
	always_comb begin
		busy       = 1'b1;
		raddr_a    = pos_q[ADDR_W-1:0];
		raddr_b    = '0;
		wr.we      = 1'b0;
		wr.addr    = idx_q;
		wr.data    = twist_word;
		draw_issue = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				busy       = 1'b0;
				draw_issue = start && (func == FUNC_DRAW) && !used_up;
			end
			ST_FILL: begin
				wr.we   = 1'b1;
				wr.data = fill_word;
			end
			ST_REGEN_PRIME: begin
				raddr_a = '0;
			end
			ST_REGEN_LOAD: begin
				raddr_a = ADDR_W'(1);
				raddr_b = MID_IDX;
			end
			ST_REGEN_RUN: begin
				raddr_a = nbr_next;
				raddr_b = far_next;
				wr.we   = 1'b1;
			end
			ST_DRAW_ISSUE: begin
				draw_issue = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

	// Advance sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_FILL;
			idx_q   <= '0;
			pos_q   <= POS_END;
			seed_q  <= SEED_DEFAULT;
			draw_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			draw_s1 <= draw_issue;
			if (accept && (func == FUNC_RESEED)) begin
				seed_q <= seed_value;
			end
			if (state_q == ST_IDLE || state_q == ST_REGEN_PRIME ||
			    state_q == ST_REGEN_LOAD) begin
				idx_q <= '0;
			end else begin
				idx_q <= idx_next;
			end
			if (draw_issue) begin
				pos_q <= pos_q + 1'b1;
			end else if (state_q == ST_FILL && idx_q == LAST_IDX) begin
				pos_q <= POS_END;
			end else if (state_q == ST_REGEN_RUN && idx_q == LAST_IDX) begin
				pos_q <= '0;
			end
		end
	end

	// Hold the previous seed word and the current twist word
	always_ff @(posedge clk) begin
		if (state_q == ST_FILL) begin
			prior_q <= fill_word;
		end
		if (state_q == ST_REGEN_LOAD || state_q == ST_REGEN_RUN) begin
			cur_q <= rdata_a;
		end
	end

	mt_state_mem u_mem (
		.clk     (clk),
		.wr      (wr),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	mt_temper u_temper (
		.clk         (clk),
		.arst_n      (arst_n),
		.rd_valid_s1 (draw_s1),
		.rd_word     (rdata_a),
		.random_word (random_word),
		.word_valid  (word_valid)
	);

	// A draw with words left produces its result through the memory read and temper registers
	a_draw_result: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && func == FUNC_DRAW && !used_up) |-> ##2 word_valid)
		else $error("draw transfer did not produce a result");

	// Read position never passes the block size
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_END)
		else $error("read position out of range");

	// End of a fill marks the block used up and returns to idle
	a_fill_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FILL && idx_q == LAST_IDX) |=> (state_q == ST_IDLE && used_up))
		else $error("fill did not finish cleanly");

	// End of regeneration rewinds the position and issues the pending draw
	a_regen_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_REGEN_RUN && idx_q == LAST_IDX) |=>
		(state_q == ST_DRAW_ISSUE && pos_q == '0))
		else $error("regeneration did not hand off to the draw");

	// No memory writes while idle
	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !wr.we)
		else $error("state memory written while idle");

endmodule

>>> tb/mt_check_pkg.sv
// Scoreboard for the MT19937 word generator: a bit-accurate predictor of the
// state block plus the queue of words still owed by the block. Depends on mt_pkg.
package mt_check_pkg;
	import mt_pkg::*;

	localparam logic [WORD_W-1:0] UPPER_MASK   = 32'h8000_0000;
	localparam logic [WORD_W-1:0] LOWER_MASK   = 32'h7FFF_FFFF;

	class mt_scoreboard;
		logic [WORD_W-1:0] twister_block [STATE_WORDS];
		int unsigned       next_index;
		logic [WORD_W-1:0] owed_words [$];
		int unsigned       mismatches;
		int unsigned       reseeds;
		int unsigned       draws;
		int unsigned       regens;
		int unsigned       words_checked;

		function new();
			seed_block(SEED_DEFAULT);
		endfunction

		// Fill the block from a seed with the initialization recurrence
		function void seed_block(logic [WORD_W-1:0] seed);
			int unsigned       k;
			logic [WORD_W-1:0] prior;
			twister_block[0] = seed;
			for (k = 1; k < STATE_WORDS; k++) begin
				prior = twister_block[k-1];
				twister_block[k] = (prior ^ (prior >> 30)) * INIT_MULT + k;
			end
			next_index = STATE_WORDS;
		endfunction

		// Regenerate the whole block in place, lowest word first
		function void twist_block();
			int unsigned       k;
			int unsigned       nbr;
			int unsigned       far_k;
			logic [WORD_W-1:0] joined;
			logic [WORD_W-1:0] mixed;
			for (k = 0; k < STATE_WORDS; k++) begin
				nbr    = (k + 1) % STATE_WORDS;
				far_k  = (k + MIDDLE_OFFSET) % STATE_WORDS;
				joined = (twister_block[k] & UPPER_MASK) | (twister_block[nbr] & LOWER_MASK);
				mixed  = joined >> 1;
				if (twister_block[nbr][0]) begin
					mixed ^= TWIST_MATRIX;
				end
				twister_block[k] = twister_block[far_k] ^ mixed;
			end
			next_index = 0;
			regens++;
		endfunction

		function logic [WORD_W-1:0] temper(logic [WORD_W-1:0] w);
			w ^= w >> 11;
			w ^= (w << 7) & TEMPER_B;
			w ^= (w << 15) & TEMPER_C;
			w ^= w >> 18;
			return w;
		endfunction

		// Advance the predictor by one accepted command
		function void note_transfer(logic op, logic [WORD_W-1:0] seed);
			if (op == FUNC_RESEED) begin
				seed_block(seed);
				reseeds++;
			end else begin
				if (next_index >= STATE_WORDS) begin
					twist_block();
				end
				owed_words.insert(owed_words.size(), temper(twister_block[next_index]));
				next_index++;
				draws++;
			end
		endfunction

		task report(string msg);
			mismatches++;
			$display("MISMATCH #%0d: %s", mismatches, msg);
		endtask

		// Compare one strobed word with the oldest owed word
		task check_word(logic [WORD_W-1:0] got);
			logic [WORD_W-1:0] want;
			if (owed_words.size() == 0) begin
				report($sformatf("random_word %h strobed with no draw outstanding", got));
			end else begin
				want = owed_words.pop_front();
				words_checked++;
				if (got !== want) begin
					report($sformatf("draw %0d: random_word %h, predicted %h",
						words_checked, got, want));
				end
			end
		endtask

		function int unsigned pending();
			return owed_words.size();
		endfunction
	endclass

endpackage

>>> tb/tb.sv
// Top of the MT19937 generator testbench: clock, reset, command driver and monitor.
// Depends on mt_pkg, mt_check_pkg and mersenne_twister_generator.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import mt_pkg::*;
	import mt_check_pkg::*;

	localparam int unsigned ITEM_TARGET   = 1750;
	localparam int unsigned IDLE_PERCENT  = 30;
	localparam int unsigned QUIET_FIRST   = 700;
	localparam int unsigned QUIET_LAST    = 1100;
	localparam int unsigned PAUSE_AT      = 900;
	localparam int unsigned SETTLE_CYCLES = 4;

	logic              clk        = 1'b0;
	logic              arst_n     = 1'b0;
	logic              start      = 1'b0;
	logic              func       = FUNC_DRAW;
	logic [WORD_W-1:0] seed_value = '0;
	logic              busy;
	logic              word_valid;
	logic [WORD_W-1:0] random_word;

	mt_scoreboard board;
	int unsigned  items_sent;
	bit           paused_once;

	always #10 clk = ~clk;

	mersenne_twister_generator i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.func       (func),
		.seed_value (seed_value),
		.random_word(random_word),
		.word_valid (word_valid)
	);

	// Check strobed words, then log the command transferred at this edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (word_valid) begin
				board.check_word(random_word);
			end
			if (start && !busy) begin
				board.note_transfer(func, seed_value);
			end
		end
	end

	// Present one command and hold it until the block takes it
	task automatic transfer_item(logic op, logic [WORD_W-1:0] seed);
		if (!(items_sent inside {[QUIET_FIRST:QUIET_LAST]}) &&
				$urandom_range(99) < IDLE_PERCENT) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		start      <= 1'b1;
		func       <= op;
		seed_value <= seed;
		@(posedge clk);
		while (busy) @(posedge clk);
		items_sent++;
	endtask

	task automatic draw_run(int unsigned count);
		repeat (count) transfer_item(FUNC_DRAW, $urandom());
	endtask

	// Drop start and hold off until every owed word has come back
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (board.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		logic [WORD_W-1:0] seed;
		int unsigned       pick;
		int unsigned       run_len;
		board = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Draws straight from the default seed; the first one regenerates
		transfer_item(FUNC_DRAW, '0);
		transfer_item(FUNC_DRAW, '1);
		transfer_item(FUNC_DRAW, 32'h5555_5555);
		// Zero and all-ones seeds
		transfer_item(FUNC_RESEED, '0);
		draw_run(2);
		transfer_item(FUNC_RESEED, '1);
		draw_run(2);
		// Explicit default seed must replay the reset sequence
		transfer_item(FUNC_RESEED, SEED_DEFAULT);
		draw_run(3);
		// Back-to-back reseeds, only the last one counts
		transfer_item(FUNC_RESEED, 32'h0000_0001);
		transfer_item(FUNC_RESEED, 32'h8000_0000);
		transfer_item(FUNC_DRAW, '1);
		transfer_item(FUNC_DRAW, 32'hAAAA_AAAA);
		drain();

		// Random sequences: mostly a reseed followed by a run of draws
		while (items_sent < ITEM_TARGET) begin
			if ($urandom_range(99) < 75) begin
				pick = $urandom_range(19);
				if (pick == 0) begin
					seed = '0;
				end else if (pick == 1) begin
					seed = '1;
				end else begin
					seed = $urandom();
				end
				transfer_item(FUNC_RESEED, seed);
			end
			pick = $urandom_range(99);
			if (pick < 10) begin
				run_len = 0;
			end else if (pick < 82) begin
				run_len = $urandom_range(1, 40);
			end else begin
				run_len = $urandom_range(600, 700);
			end
			// Trim the last run so the total stays near the target
			if (run_len > ITEM_TARGET - items_sent) begin
				run_len = ITEM_TARGET - items_sent;
			end
			draw_run(run_len);
			if (!paused_once && items_sent >= PAUSE_AT) begin
				drain();
				paused_once = 1'b1;
			end
		end

		drain();
		$display("Run covered %0d commands: %0d reseeds, %0d draws, %0d block regenerations.",
			items_sent, board.reseeds, board.draws, board.regens);
		$display("Checked %0d words, %0d mismatches.", board.words_checked, board.mismatches);
		if (board.mismatches == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#100_000_000;
		$display("TIMEOUT after %0d commands, %0d words outstanding", items_sent,
			board.pending());
		$display("Some tests failed");
		$finish;
	end

endmodule
